// ===== rtl/rtt_pkg.sv =====
// retransmit timer table: shared types, command and status codes
// no dependencies
package rtt_pkg;
   localparam int DefTableDepth = 16;
   localparam logic [31:0] DefResendPeriod = 32'd100000;

   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_LOOKUP = 3'd2,
      CMD_SCAN   = 3'd3,
      CMD_OLDEST = 3'd4
   } cmd_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   localparam logic [0:0] REG_RESEND_PERIOD = 1'd0;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] ident;
      logic [15:0] pkt_size;
      logic [63:0] time_us;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] res_ident;
      logic [15:0] res_size;
      logic [63:0] res_stamp;
      logic [4:0]  count;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_SHIFT,
      S_EMIT,
      S_DONE
   } state_type;
endpackage

// ===== rtl/rtt_req_queue.sv =====
// retransmit timer table: two-entry request queue between front and engine
// depends on rtt_pkg
module rtt_req_queue
   import rtt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type push_data,
   input  logic    pop,
   output logic    empty,
   output req_type pop_data
);
   req_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push && !full) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop && !empty) rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push && !full) - 2'(pop && !empty);
      end
   end
endmodule

// ===== rtl/rtt_engine.sv =====
// retransmit timer table: entry store and command sequencer, one entry per cycle
// unless a scan holds for a busy output; depends on rtt_pkg
module rtt_engine
   import rtt_pkg::*;
#(
   parameter int TableDepth = DefTableDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] resend_period,
   input  logic        cmd_valid,
   input  req_type     cmd,
   output logic        cmd_take,
   output logic        rsp_valid,
   output rsp_type     rsp,
   input  logic        rsp_ready
);
   localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
   localparam int CntW = $clog2(TableDepth + 1);

   logic [15:0] ids_ff    [TableDepth];
   logic [15:0] sizes_ff  [TableDepth];
   logic [63:0] stamps_ff [TableDepth];

   state_type     state_ff, state_in;
   req_type       cur_ff, cur_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] hit_ff, hit_in;
   logic            found_ff, found_in;
   logic [CntW-1:0] sent_ff, sent_in;
   logic [63:0]     best_ff, best_in;
   rsp_type         out_ff, out_in;
   logic            out_valid_ff, out_valid_in;

   logic [IdxW-1:0] ix, hx;
   logic [15:0]     e_id, e_size, h_id, h_size;
   logic [63:0]     e_stamp, h_stamp;
   logic [64:0]     due;
   logic            expired;
   logic            out_free;
   logic            wr_stamp;
   logic            wr_ins;
   logic            do_shift;

   assign ix      = idx_ff[IdxW-1:0];
   assign hx      = hit_ff[IdxW-1:0];
   assign e_id    = ids_ff[ix];
   assign e_size  = sizes_ff[ix];
   assign e_stamp = stamps_ff[ix];
   assign h_id    = ids_ff[hx];
   assign h_size  = sizes_ff[hx];
   assign h_stamp = stamps_ff[hx];
   assign due     = {1'b0, e_stamp} + {33'd0, resend_period};
   assign expired = ({1'b0, cur_ff.time_us} > due);
   assign out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      sent_in      = sent_ff;
      best_in      = best_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      cmd_take     = 1'b0;
      wr_stamp     = 1'b0;
      wr_ins       = 1'b0;
      do_shift     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_take = 1'b1;
               cur_in   = cmd;
               idx_in   = '0;
               hit_in   = '0;
               found_in = 1'b0;
               sent_in  = '0;
               case (cmd.command)
                  CMD_INSERT: begin
                     out_valid_in     = 1'b1;
                     out_in.res_ident = cmd.ident;
                     out_in.res_size  = cmd.pkt_size;
                     out_in.res_stamp = cmd.time_us;
                     out_in.last      = 1'b1;
                     if (fill_ff >= CntW'(TableDepth)) begin
                        out_in.status = ST_FULL;
                        out_in.count  = 5'(fill_ff);
                     end else begin
                        wr_ins        = 1'b1;
                        out_in.status = ST_OK;
                        fill_in       = fill_ff + 1'b1;
                        out_in.count  = 5'(fill_ff + 1'b1);
                     end
                  end
                  CMD_REMOVE, CMD_LOOKUP, CMD_SCAN, CMD_OLDEST: begin
                     state_in = S_WALK;
                  end
                  default: begin
                     out_valid_in = 1'b1;
                     out_in       = '{status: ST_OK, res_ident: 16'd0, res_size: 16'd0,
                                      res_stamp: 64'd0, count: 5'(fill_ff), last: 1'b1};
                  end
               endcase
            end
         end
         S_WALK: begin
            if (idx_ff >= fill_ff) begin
               state_in = S_DONE;
            end else begin
               case (cur_ff.command)
                  CMD_REMOVE, CMD_LOOKUP: begin
                     if (e_id == cur_ff.ident) begin
                        found_in = 1'b1;
                        hit_in   = idx_ff;
                        state_in = S_DONE;
                     end else begin
                        idx_in = idx_ff + 1'b1;
                     end
                  end
                  CMD_SCAN: begin
                     if (expired) begin
                        if (out_free) begin
                           wr_stamp     = 1'b1;
                           sent_in      = sent_ff + 1'b1;
                           out_valid_in = 1'b1;
                           out_in       = '{status: ST_OK, res_ident: e_id,
                                            res_size: e_size,
                                            res_stamp: cur_ff.time_us,
                                            count: 5'(fill_ff), last: 1'b0};
                           idx_in       = idx_ff + 1'b1;
                        end
                     end else begin
                        idx_in = idx_ff + 1'b1;
                     end
                  end
                  default: begin
                     // oldest query: keep the first entry with the smallest stamp
                     if (!found_ff || e_stamp < best_ff) begin
                        found_in = 1'b1;
                        hit_in   = idx_ff;
                        best_in  = e_stamp;
                     end
                     idx_in = idx_ff + 1'b1;
                  end
               endcase
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.last  = 1'b1;
               out_in.status = ST_OK;
               state_in     = S_IDLE;
               case (cur_ff.command)
                  CMD_SCAN: begin
                     out_in.res_ident = 16'd0;
                     out_in.res_size  = 16'd0;
                     out_in.res_stamp = cur_ff.time_us;
                     out_in.count     = 5'(sent_ff);
                  end
                  CMD_OLDEST: begin
                     out_in.count     = 5'(fill_ff);
                     out_in.res_ident = found_ff ? h_id : 16'd0;
                     out_in.res_size  = found_ff ? h_size : 16'd0;
                     out_in.res_stamp = found_ff ? best_ff : 64'd0;
                  end
                  default: begin
                     out_in.res_ident = cur_ff.ident;
                     if (!found_ff) begin
                        out_in.status    = ST_NOT_FOUND;
                        out_in.res_size  = 16'd0;
                        out_in.res_stamp = 64'd0;
                        out_in.count     = 5'(fill_ff);
                     end else begin
                        out_in.res_size  = h_size;
                        out_in.res_stamp = h_stamp;
                        if (cur_ff.command == CMD_REMOVE) begin
                           out_valid_in = 1'b0;
                           out_in       = out_ff;
                           idx_in       = hit_ff;
                           state_in     = S_SHIFT;
                        end else begin
                           out_in.count = 5'(fill_ff);
                        end
                     end
                  end
               endcase
            end
         end
         S_SHIFT: begin
            // the hit is parked in the request register on entry; the gap is closed one entry a cycle
            if (idx_ff == hit_ff && !found_ff) begin
               state_in = S_IDLE;
            end else if (idx_ff + 1'b1 >= fill_ff) begin
               fill_in      = fill_ff - 1'b1;
               state_in     = S_EMIT;
            end else begin
               do_shift = 1'b1;
               idx_in   = idx_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = '{status: ST_OK, res_ident: cur_ff.ident, res_size: cur_ff.pkt_size,
                                res_stamp: cur_ff.time_us, count: 5'(fill_ff), last: 1'b1};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // remove: park the hit entry's fields in the request register before the shift
      if (state_ff == S_DONE && state_in == S_SHIFT) begin
         cur_in.pkt_size = h_size;
         cur_in.time_us  = h_stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ins) begin
         ids_ff[fill_ff[IdxW-1:0]]    <= cmd.ident;
         sizes_ff[fill_ff[IdxW-1:0]]  <= cmd.pkt_size;
         stamps_ff[fill_ff[IdxW-1:0]] <= cmd.time_us;
      end else if (wr_stamp) begin
         stamps_ff[ix] <= cur_ff.time_us;
      end else if (do_shift) begin
         ids_ff[ix]    <= ids_ff[IdxW'(idx_ff + 1'b1)];
         sizes_ff[ix]  <= sizes_ff[IdxW'(idx_ff + 1'b1)];
         stamps_ff[ix] <= stamps_ff[IdxW'(idx_ff + 1'b1)];
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      idx_ff  <= idx_in;
      hit_ff  <= hit_in;
      sent_ff <= sent_in;
      best_ff <= best_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         found_ff     <= found_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule

// ===== rtl/rtt_rsp_queue.sv =====
// retransmit timer table: two-entry result queue towards the receiver
// depends on rtt_pkg
module rtt_rsp_queue
   import rtt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    in_ready,
   input  logic    pop,
   output logic    empty,
   output rsp_type pop_data
);
   rsp_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign in_ready = (cnt_ff != 2'd2);
   assign wr       = in_valid && in_ready;
   assign rd       = pop && !empty;
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wr_ptr_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (wr) wr_ptr_ff <= ~wr_ptr_ff;
         if (rd) rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
   end
endmodule

// ===== rtl/retransmit_timer_table.sv =====
// retransmit timer table: top level, register port and channel wiring
// depends on rtt_pkg, rtt_req_queue, rtt_engine, rtt_rsp_queue
//
// Use: push a request transaction (req_push while !req_full); results come
// out of a queue (rsp_pop while !rsp_empty). Each command gives one result
// with last set; an expiry scan gives one result per resent entry first.
// Requests land in a two-deep queue, so the sender is held only once two
// requests wait. The engine walks the table one entry per cycle, but a scan
// holds at an expired entry while the result queue is full. A result passes
// from the engine's output register into the result queue before it reaches
// rsp_data. If the receiver stops popping, the result queue fills and the
// engine holds at its next result; requests keep queuing until req_full.
// Reset empties both queues and the table and sets resend_period to 100000.
// csr_ is an APB-style port; register 0 (byte 0) is resend_period.
module retransmit_timer_table
   import rtt_pkg::*;
#(
   parameter int TableDepth = DefTableDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [31:0] period_ff;
   logic        q_empty, take, e_valid, e_ready;
   req_type     q_data;
   rsp_type     e_rsp;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:1] == REG_RESEND_PERIOD) ? period_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) period_ff <= DefResendPeriod;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:1] == REG_RESEND_PERIOD)
         period_ff <= csr_pwdata;
   end

   rtt_req_queue u_reqq (
      .clock, .reset, .push(req_push), .full(req_full), .push_data(req_data),
      .pop(take), .empty(q_empty), .pop_data(q_data)
   );

   rtt_engine #(.TableDepth(TableDepth)) u_eng (
      .clock, .reset, .resend_period(period_ff), .cmd_valid(!q_empty),
      .cmd(q_data), .cmd_take(take), .rsp_valid(e_valid), .rsp(e_rsp),
      .rsp_ready(e_ready)
   );

   rtt_rsp_queue u_rspq (
      .clock, .reset, .in_valid(e_valid), .in_data(e_rsp), .in_ready(e_ready),
      .pop(rsp_pop), .empty(rsp_empty), .pop_data(rsp_data)
   );
endmodule

// ===== rtl/rtt_checker.sv =====
// retransmit timer table: port-level checker and its bind
// depends on rtt_pkg and retransmit_timer_table
module rtt_checker
   import rtt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data,
   input logic    csr_pready
);
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("results present after reset");
   a_not_full_after_reset: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request queue full after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("waiting result changed");
   a_status: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.status != 2'd3))
      else $error("bad status code");
   a_ready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind retransmit_timer_table rtt_checker u_chk (
   .clock, .reset, .req_full, .rsp_empty, .rsp_pop, .rsp_data, .csr_pready
);
